>>> rtl/npdb_pkg.sv
`timescale 1ns / 1ps
// npdb_pkg: shared widths, command and status codes, register indexes,
// sequencer states and the token that walks the bin cell chain.
// No dependencies.
package npdb_pkg;

    localparam int CODE_W    = 20;
    localparam int LIMIT_W   = 24;
    localparam int COUNT_W   = 32;
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 3;
    localparam int BIN_W     = 2;
    localparam int NUM_BINS  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_OFFER = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] STAT_STORED     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_SKIPPED    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_CLASSIFIED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_CLEARED    = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT   = 2'd3;

    // register index and reset value of the limit held by each bounded bin cell
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_IDX [NUM_BINS-1] =
        '{CFG_NEAR_LIMIT, CFG_MID_LIMIT, CFG_FAR_LIMIT};
    localparam logic [LIMIT_W-1:0] LIMIT_RESET [NUM_BINS] =
        '{24'd1000, 24'd2000, 24'd5000, 24'd0};

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_CHAIN
    } t_state;

    typedef struct packed {
        logic             valid;
        logic             claimed;
        logic             empty;
        logic [BIN_W-1:0] bin;
    } t_token;

endpackage

>>> rtl/npdb_ram.sv
`timescale 1ns / 1ps
// npdb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module npdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/npdb_bin_cell.sv
`timescale 1ns / 1ps
// npdb_bin_cell: one distance bin. Holds its limit, the squared limit and a
// saturating count; claims a passing token when the distance fits. Uses npdb_pkg.
module npdb_bin_cell #(
    parameter int                          BIN_IDX   = 0,
    parameter logic [npdb_pkg::LIMIT_W-1:0] LIMIT_RST = '0,
    parameter int                          DIST_W    = 52
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_clear,
    input  logic                            i_cfg_we,
    input  logic [npdb_pkg::LIMIT_W-1:0]    i_cfg_limit,
    input  npdb_pkg::t_token                i_tok,
    input  logic [DIST_W-1:0]               i_dist,
    output npdb_pkg::t_token                o_tok,
    output logic [DIST_W-1:0]               o_dist,
    output logic [npdb_pkg::COUNT_W-1:0]    o_count
);

    localparam int  LSQ_W     = 2 * npdb_pkg::LIMIT_W;
    localparam int  CMP_W     = (DIST_W > LSQ_W) ? DIST_W : LSQ_W;
    localparam bit  CATCH_ALL = (BIN_IDX == npdb_pkg::NUM_BINS - 1);

    logic [npdb_pkg::LIMIT_W-1:0] r_limit;
    logic [LSQ_W-1:0]             r_limit_sq;
    logic [npdb_pkg::COUNT_W-1:0] r_count;
    logic [npdb_pkg::COUNT_W-1:0] n_count;
    npdb_pkg::t_token             r_tok;
    npdb_pkg::t_token             n_tok;
    logic [DIST_W-1:0]            r_dist;
    logic                         fits;
    logic                         hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_limit;
        end
    end

    // squared limit is registered from the limit; queries take longer to reach the cell
    always_ff @(posedge i_clk) begin
        r_limit_sq <= r_limit * r_limit;
    end

    assign fits = CATCH_ALL || (!i_tok.empty && (CMP_W'(i_dist) <= CMP_W'(r_limit_sq)));
    assign hit  = i_tok.valid && !i_tok.claimed && fits;

    always_comb begin
        n_count = r_count;
        if (i_clear) begin
            n_count = '0;
        end else if (hit && (r_count != '1)) begin
            n_count = r_count + npdb_pkg::COUNT_W'(1);
        end
    end

    always_comb begin
        n_tok         = i_tok;
        n_tok.claimed = i_tok.claimed || hit;
        if (hit) begin
            n_tok.bin = npdb_pkg::BIN_W'(BIN_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_tok   <= '0;
        end else begin
            r_count <= n_count;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= i_dist;
    end

    assign o_tok   = r_tok;
    assign o_dist  = r_dist;
    assign o_count = r_count;

endmodule

>>> rtl/nearest_point_distance_binner.sv
`timescale 1ns / 1ps
// nearest_point_distance_binner: top level. Location table, scan pipeline,
// sequencer and the chain of bin cells. Uses npdb_pkg, npdb_ram, npdb_bin_cell.
//
// Keeps a table of service locations and classifies residence queries by the
// squared distance to the nearest stored location. A request is taken when
// i_start is high and o_busy is low. Offer, clear and unknown actions finish
// at once: the result strobe comes in the next cycle and a new request may be
// taken in that same cycle. A query reads the table one location per cycle
// through the single RAM read port, then passes a token down four bin cells;
// it holds o_busy until the token leaves the last cell, and its result strobe
// comes in the same cycle that o_busy drops. Each result is shown for
// one cycle with o_result_strobe; there is no backpressure, so the receiver
// must take it then. The count, stored_count and nearest_valid outputs track
// the live state and are valid with every strobe. Configuration writes are
// always ready and are meant for an idle block. The table needs no clearing
// after reset: only entries below stored_count are ever read.
module nearest_point_distance_binner #(
    parameter int MAX_LOCATIONS = 1024,
    parameter int COORD_BITS    = 25
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    // request channel
    input  logic                                         i_start,
    output logic                                         o_busy,
    input  logic [npdb_pkg::ACTION_W-1:0]                i_action,
    input  logic [npdb_pkg::CODE_W-1:0]                  i_category,
    input  logic signed [COORD_BITS-1:0]                 i_pos_x,
    input  logic signed [COORD_BITS-1:0]                 i_pos_y,
    // configuration write channel
    input  logic                                         i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  logic [npdb_pkg::CFG_IDX_W-1:0]               i_cfg_addr,
    input  logic [npdb_pkg::CFG_DATA_W-1:0]              i_cfg_data,
    // result
    output logic                                         o_result_strobe,
    output logic [npdb_pkg::STATUS_W-1:0]                o_status,
    output logic [npdb_pkg::BIN_W-1:0]                   o_bin,
    output logic [2*COORD_BITS+1:0]                      o_nearest_dist_sq,
    output logic                                         o_nearest_valid,
    output logic [npdb_pkg::COUNT_W-1:0]                 o_count_near,
    output logic [npdb_pkg::COUNT_W-1:0]                 o_count_second,
    output logic [npdb_pkg::COUNT_W-1:0]                 o_count_third,
    output logic [npdb_pkg::COUNT_W-1:0]                 o_count_beyond,
    output logic [$clog2(MAX_LOCATIONS+1)-1:0]           o_stored_count
);

    localparam int AW    = (MAX_LOCATIONS > 1) ? $clog2(MAX_LOCATIONS) : 1;
    localparam int CNT_W = $clog2(MAX_LOCATIONS + 1);
    localparam int DW    = 2 * COORD_BITS + 2;   // sum of two squared differences
    localparam int AD_W  = COORD_BITS + 1;       // magnitude of one difference
    localparam int NB    = npdb_pkg::NUM_BINS;

    // ---------------------------------------------------------------- control
    npdb_pkg::t_state r_state;
    npdb_pkg::t_state n_state;

    logic accept;
    logic is_query;
    logic is_offer;
    logic is_clear;
    logic cfg_wr;
    logic table_full;
    logic code_match;
    logic store_we;
    logic last_addr;
    logic pipe_empty;
    logic chain_done;
    logic issue;
    logic launch_scan;
    logic launch_empty;

    logic [npdb_pkg::CODE_W-1:0] r_wanted_code;
    logic [CNT_W-1:0]            r_loc_count;

    assign o_busy      = (r_state != npdb_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;
    assign is_query    = accept && (i_action == npdb_pkg::ACT_QUERY);
    assign is_offer    = accept && (i_action == npdb_pkg::ACT_OFFER);
    assign is_clear    = accept && (i_action == npdb_pkg::ACT_CLEAR);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign table_full  = (r_loc_count == CNT_W'(MAX_LOCATIONS));
    assign code_match  = (i_category == r_wanted_code);
    assign store_we    = is_offer && code_match && !table_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_code <= '0;
        end else if (cfg_wr && (i_cfg_addr == npdb_pkg::CFG_WANTED_CODE)) begin
            r_wanted_code <= i_cfg_data[npdb_pkg::CODE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loc_count <= '0;
        end else if (is_clear) begin
            r_loc_count <= '0;
        end else if (store_we) begin
            r_loc_count <= r_loc_count + CNT_W'(1);
        end
    end

    // ---------------------------------------------------------------- table
    logic [AW-1:0]             r_addr;
    logic [2*COORD_BITS-1:0]   rd_data;

    npdb_ram #(
        .WIDTH(2 * COORD_BITS),
        .DEPTH(MAX_LOCATIONS)
    ) u_loc_ram (
        .i_clk  (i_clk),
        .i_we   (store_we),
        .i_waddr(r_loc_count[AW-1:0]),
        .i_wdata({i_pos_y, i_pos_x}),
        .i_raddr(r_addr),
        .o_rdata(rd_data)
    );

    // ---------------------------------------------------------------- sequencer
    assign last_addr = (CNT_W'(r_addr) == (r_loc_count - CNT_W'(1)));

    always_comb begin
        n_state = r_state;
        case (r_state)
            npdb_pkg::S_IDLE: begin
                if (is_query) begin
                    n_state = (r_loc_count == '0) ? npdb_pkg::S_CHAIN : npdb_pkg::S_SCAN;
                end
            end
            npdb_pkg::S_SCAN: begin
                if (last_addr) begin
                    n_state = npdb_pkg::S_DRAIN;
                end
            end
            npdb_pkg::S_DRAIN: begin
                if (pipe_empty) begin
                    n_state = npdb_pkg::S_CHAIN;
                end
            end
            npdb_pkg::S_CHAIN: begin
                if (chain_done) begin
                    n_state = npdb_pkg::S_IDLE;
                end
            end
            default: n_state = npdb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        issue        = 1'b0;
        launch_scan  = 1'b0;
        launch_empty = 1'b0;
        case (r_state)
            npdb_pkg::S_IDLE:  launch_empty = is_query && (r_loc_count == '0);
            npdb_pkg::S_SCAN:  issue        = 1'b1;
            npdb_pkg::S_DRAIN: launch_scan  = pipe_empty;
            npdb_pkg::S_CHAIN: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npdb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------- scan pipe
    // read -> |difference| -> squares -> sum and running minimum
    logic signed [COORD_BITS-1:0] r_qx;
    logic signed [COORD_BITS-1:0] r_qy;
    logic                         r_v1;
    logic                         r_v2;
    logic                         r_v3;
    logic signed [AD_W-1:0]       dx;
    logic signed [AD_W-1:0]       dy;
    logic [AD_W-1:0]              r_ax;
    logic [AD_W-1:0]              r_ay;
    logic [DW-1:0]                r_sqx;
    logic [DW-1:0]                r_sqy;
    logic [DW-1:0]                dist_sum;
    logic [DW-1:0]                r_best;
    logic                         r_have_best;

    always_ff @(posedge i_clk) begin
        if (is_query) begin
            r_qx <= i_pos_x;
            r_qy <= i_pos_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (is_query) begin
            r_addr <= '0;
        end else if (issue) begin
            r_addr <= r_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign pipe_empty = !r_v1 && !r_v2 && !r_v3;

    assign dx = AD_W'(r_qx) - AD_W'($signed(rd_data[COORD_BITS-1:0]));
    assign dy = AD_W'(r_qy) - AD_W'($signed(rd_data[2*COORD_BITS-1:COORD_BITS]));

    always_ff @(posedge i_clk) begin
        r_ax  <= dx[AD_W-1] ? AD_W'(-dx) : AD_W'(dx);
        r_ay  <= dy[AD_W-1] ? AD_W'(-dy) : AD_W'(dy);
        r_sqx <= r_ax * r_ax;
        r_sqy <= r_ay * r_ay;
    end

    assign dist_sum = r_sqx + r_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best <= 1'b0;
        end else if (is_query) begin
            r_have_best <= 1'b0;
        end else if (r_v3) begin
            r_have_best <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && (!r_have_best || (dist_sum < r_best))) begin
            r_best <= dist_sum;
        end
    end

    // ---------------------------------------------------------------- bin chain
    npdb_pkg::t_token                 r_tok_in;
    logic [DW-1:0]                    r_dist_in;
    npdb_pkg::t_token                 tok    [NB+1];
    logic [DW-1:0]                    dist_c [NB+1];
    logic [npdb_pkg::COUNT_W-1:0]     counts [NB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_in <= '0;
        end else begin
            r_tok_in.valid   <= launch_scan || launch_empty;
            r_tok_in.claimed <= 1'b0;
            r_tok_in.empty   <= launch_empty;
            r_tok_in.bin     <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist_in <= launch_scan ? r_best : '0;
    end

    assign tok[0]    = r_tok_in;
    assign dist_c[0] = r_dist_in;

    for (genvar k = 0; k < NB; k++) begin : g_cell
        logic cell_we;
        if (k < NB - 1) begin : g_bounded
            assign cell_we = cfg_wr && (i_cfg_addr == npdb_pkg::CFG_LIMIT_IDX[k]);
        end else begin : g_beyond
            assign cell_we = 1'b0;
        end

        npdb_bin_cell #(
            .BIN_IDX  (k),
            .LIMIT_RST(npdb_pkg::LIMIT_RESET[k]),
            .DIST_W   (DW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_clear    (is_clear),
            .i_cfg_we   (cell_we),
            .i_cfg_limit(i_cfg_data[npdb_pkg::LIMIT_W-1:0]),
            .i_tok      (tok[k]),
            .i_dist     (dist_c[k]),
            .o_tok      (tok[k+1]),
            .o_dist     (dist_c[k+1]),
            .o_count    (counts[k])
        );
    end

    assign chain_done = tok[NB].valid;

    // ---------------------------------------------------------------- result
    logic                          r_strobe;
    logic [npdb_pkg::STATUS_W-1:0] r_status;
    logic [npdb_pkg::BIN_W-1:0]    r_bin;
    logic [DW-1:0]                 r_dist;
    logic [npdb_pkg::STATUS_W-1:0] quick_status;
    logic                          quick_done;

    assign quick_done = accept && (i_action != npdb_pkg::ACT_QUERY);

    always_comb begin
        case (i_action)
            npdb_pkg::ACT_OFFER: begin
                if (!code_match) begin
                    quick_status = npdb_pkg::STAT_SKIPPED;
                end else if (table_full) begin
                    quick_status = npdb_pkg::STAT_FULL;
                end else begin
                    quick_status = npdb_pkg::STAT_STORED;
                end
            end
            npdb_pkg::ACT_CLEAR: quick_status = npdb_pkg::STAT_CLEARED;
            default:             quick_status = npdb_pkg::STAT_SKIPPED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= quick_done || chain_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (chain_done) begin
            r_status <= npdb_pkg::STAT_CLASSIFIED;
            r_bin    <= tok[NB].bin;
            r_dist   <= dist_c[NB];
        end else if (quick_done) begin
            r_status <= quick_status;
            r_bin    <= '0;
            r_dist   <= '0;
        end
    end

    assign o_result_strobe   = r_strobe;
    assign o_status          = r_status;
    assign o_bin             = r_bin;
    assign o_nearest_dist_sq = r_dist;
    assign o_nearest_valid   = (r_loc_count != '0);
    assign o_count_near      = counts[0];
    assign o_count_second    = counts[1];
    assign o_count_third     = counts[2];
    assign o_count_beyond    = counts[3];
    assign o_stored_count    = r_loc_count;

    // ---------------------------------------------------------------- checks
    a_strobe_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == npdb_pkg::S_IDLE))
        else $error("result strobe while a query is in progress");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({tok[0].valid, tok[1].valid, tok[2].valid, tok[3].valid,
                    tok[4].valid}) <= 1)
        else $error("more than one token in the bin chain");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loc_count <= CNT_W'(MAX_LOCATIONS))
        else $error("stored count beyond table depth");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == npdb_pkg::S_SCAN) |-> (CNT_W'(r_addr) < r_loc_count))
        else $error("scan address past stored locations");

    a_launch_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_tok_in.valid) && !r_tok_in.empty |-> pipe_empty)
        else $error("token launched before scan pipe drained");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for nearest_point_distance_binner; queued requests and
// register writes, in-bench prediction of every result. Needs npdb_pkg and the RTL.
module tb;

    localparam int          MAX_LOC      = 1024;
    localparam int          COORD_BITS   = 25;
    localparam int          DIST_W       = 2 * COORD_BITS + 2;
    localparam int          STORED_W     = $clog2(MAX_LOC + 1);
    localparam longint      COORD_MAX    = 16777215;
    localparam longint      COORD_MIN    = -16777216;
    // about 580 requests, each at most a full-table scan plus gaps
    localparam int unsigned CYCLE_LIMIT  = 5000000;
    localparam int          DRAIN_CYCLES = 32;

    // action code the block ignores
    localparam logic [npdb_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic [npdb_pkg::BIN_W-1:0] BIN_NEAR   = 2'd0;
    localparam logic [npdb_pkg::BIN_W-1:0] BIN_SECOND = 2'd1;
    localparam logic [npdb_pkg::BIN_W-1:0] BIN_THIRD  = 2'd2;
    localparam logic [npdb_pkg::BIN_W-1:0] BIN_BEYOND = 2'd3;

    typedef enum bit {ENTRY_REQUEST, ENTRY_CFG_WRITE} t_entry_kind;

    typedef struct {
        t_entry_kind                          kind;
        logic [npdb_pkg::ACTION_W-1:0]        action;
        logic [npdb_pkg::CODE_W-1:0]          category;
        logic signed [COORD_BITS-1:0]         pos_x;
        logic signed [COORD_BITS-1:0]         pos_y;
        logic [npdb_pkg::CFG_IDX_W-1:0]       cfg_addr;
        logic [npdb_pkg::CFG_DATA_W-1:0]      cfg_data;
        int unsigned                          gap_pct;
    } t_pending;

    typedef struct {
        logic [npdb_pkg::STATUS_W-1:0]                          status;
        logic [npdb_pkg::BIN_W-1:0]                             bin;
        logic [DIST_W-1:0]                                      dist_sq;
        logic                                                   valid;
        logic [npdb_pkg::NUM_BINS-1:0][npdb_pkg::COUNT_W-1:0]   counts;
        logic [STORED_W-1:0]                                    stored;
    } t_outcome;

    logic                                  i_clk       = 1'b0;
    logic                                  i_rst_n     = 1'b0;
    logic                                  i_start     = 1'b0;
    logic [npdb_pkg::ACTION_W-1:0]         i_action    = '0;
    logic [npdb_pkg::CODE_W-1:0]           i_category  = '0;
    logic signed [COORD_BITS-1:0]          i_pos_x     = '0;
    logic signed [COORD_BITS-1:0]          i_pos_y     = '0;
    logic                                  i_cfg_valid = 1'b0;
    logic [npdb_pkg::CFG_IDX_W-1:0]        i_cfg_addr  = '0;
    logic [npdb_pkg::CFG_DATA_W-1:0]       i_cfg_data  = '0;
    logic                                  o_busy;
    logic                                  o_cfg_ready;
    logic                                  o_result_strobe;
    logic [npdb_pkg::STATUS_W-1:0]         o_status;
    logic [npdb_pkg::BIN_W-1:0]            o_bin;
    logic [DIST_W-1:0]                     o_nearest_dist_sq;
    logic                                  o_nearest_valid;
    logic [npdb_pkg::COUNT_W-1:0]          o_count_near;
    logic [npdb_pkg::COUNT_W-1:0]          o_count_second;
    logic [npdb_pkg::COUNT_W-1:0]          o_count_third;
    logic [npdb_pkg::COUNT_W-1:0]          o_count_beyond;
    logic [STORED_W-1:0]                   o_stored_count;

    nearest_point_distance_binner #(
        .MAX_LOCATIONS(MAX_LOC),
        .COORD_BITS   (COORD_BITS)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_action          (i_action),
        .i_category        (i_category),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .o_result_strobe   (o_result_strobe),
        .o_status          (o_status),
        .o_bin             (o_bin),
        .o_nearest_dist_sq (o_nearest_dist_sq),
        .o_nearest_valid   (o_nearest_valid),
        .o_count_near      (o_count_near),
        .o_count_second    (o_count_second),
        .o_count_third     (o_count_third),
        .o_count_beyond    (o_count_beyond),
        .o_stored_count    (o_stored_count)
    );

    initial forever #1 i_clk = ~i_clk;

    // requests and register writes waiting to go out, and the one on the wires
    t_pending    pending [$];
    t_pending    on_wire;
    int unsigned fill_gap = 12;

    // results predicted for accepted requests, oldest first
    t_outcome    awaited_outcomes [$];
    int unsigned requests_taken = 0;
    int unsigned results_done   = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // predicted block state: location table, bin tallies, registers
    longint                       loc_x [$];
    longint                       loc_y [$];
    logic [npdb_pkg::COUNT_W-1:0] bin_tally [npdb_pkg::NUM_BINS] = '{default: '0};
    logic [npdb_pkg::CODE_W-1:0]  code_sel = '0;
    logic [npdb_pkg::LIMIT_W-1:0] bin_limit [npdb_pkg::NUM_BINS-1] =
        '{24'd1000, 24'd2000, 24'd5000};

    // points offered in the current random stretch, used to aim queries
    longint offered_x [$];
    longint offered_y [$];

    function automatic void apply_register_write(
        input logic [npdb_pkg::CFG_IDX_W-1:0]  addr,
        input logic [npdb_pkg::CFG_DATA_W-1:0] data);
        case (addr)
            npdb_pkg::CFG_WANTED_CODE: code_sel = data[npdb_pkg::CODE_W-1:0];
            npdb_pkg::CFG_NEAR_LIMIT:  bin_limit[0] = data;
            npdb_pkg::CFG_MID_LIMIT:   bin_limit[1] = data;
            npdb_pkg::CFG_FAR_LIMIT:   bin_limit[2] = data;
            default: ;
        endcase
    endfunction

    // Applies one request to the predicted state and returns the result it gives.
    function automatic t_outcome classify_and_update(input t_pending req);
        t_outcome        res;
        longint          dx;
        longint          dy;
        longint unsigned d;
        longint unsigned best;
        longint unsigned lim_sq [npdb_pkg::NUM_BINS-1];
        int              j;
        res.status  = npdb_pkg::STAT_SKIPPED;
        res.bin     = BIN_NEAR;
        res.dist_sq = '0;
        best        = 0;
        case (req.action)
            npdb_pkg::ACT_OFFER: begin
                if (req.category != code_sel) begin
                    res.status = npdb_pkg::STAT_SKIPPED;
                end else if (loc_x.size() >= MAX_LOC) begin
                    res.status = npdb_pkg::STAT_FULL;
                end else begin
                    loc_x = {loc_x, longint'(req.pos_x)};
                    loc_y = {loc_y, longint'(req.pos_y)};
                    res.status = npdb_pkg::STAT_STORED;
                end
            end
            npdb_pkg::ACT_QUERY: begin
                res.status = npdb_pkg::STAT_CLASSIFIED;
                if (loc_x.size() == 0) begin
                    res.bin = BIN_BEYOND;
                end else begin
                    for (j = 0; j < loc_x.size(); j++) begin
                        dx = longint'(req.pos_x) - loc_x[j];
                        dy = longint'(req.pos_y) - loc_y[j];
                        d  = dx * dx + dy * dy;
                        if (j == 0 || d < best) best = d;
                    end
                    for (j = 0; j < npdb_pkg::NUM_BINS - 1; j++) begin
                        lim_sq[j] = bin_limit[j];
                        lim_sq[j] = lim_sq[j] * lim_sq[j];
                    end
                    res.dist_sq = best[DIST_W-1:0];
                    // compare squared values; a zero distance always lands in the near bin
                    if (best <= lim_sq[0])      res.bin = BIN_NEAR;
                    else if (best <= lim_sq[1]) res.bin = BIN_SECOND;
                    else if (best <= lim_sq[2]) res.bin = BIN_THIRD;
                    else                        res.bin = BIN_BEYOND;
                end
                if (bin_tally[res.bin] != '1) bin_tally[res.bin]++;
            end
            npdb_pkg::ACT_CLEAR: begin
                loc_x.delete();
                loc_y.delete();
                bin_tally  = '{default: '0};
                res.status = npdb_pkg::STAT_CLEARED;
            end
            default: res.status = npdb_pkg::STAT_SKIPPED;
        endcase
        res.valid = loc_x.size() != 0;
        for (j = 0; j < npdb_pkg::NUM_BINS; j++) res.counts[j] = bin_tally[j];
        res.stored = STORED_W'(loc_x.size());
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, results_done, msg);
        mismatch_count++;
    endtask

    function automatic logic signed [COORD_BITS-1:0] to_coord(input longint v);
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic longint any_coord();
        bit [31:0] r;
        r = $urandom();
        return longint'($signed(r[COORD_BITS-1:0]));
    endfunction

    function automatic longint jitter(input int s);
        return longint'($urandom_range(2 * s)) - s;
    endfunction

    task automatic add_request(input logic [npdb_pkg::ACTION_W-1:0] act,
                               input logic [npdb_pkg::CODE_W-1:0] cat,
                               input longint x, input longint y);
        t_pending e;
        e.kind     = ENTRY_REQUEST;
        e.action   = act;
        e.category = cat;
        e.pos_x    = to_coord(x);
        e.pos_y    = to_coord(y);
        e.cfg_addr = '0;
        e.cfg_data = '0;
        e.gap_pct  = fill_gap;
        pending = {pending, e};
    endtask

    task automatic add_cfg(input logic [npdb_pkg::CFG_IDX_W-1:0] addr,
                           input logic [npdb_pkg::CFG_DATA_W-1:0] data);
        t_pending e;
        e.kind     = ENTRY_CFG_WRITE;
        e.action   = npdb_pkg::ACT_OFFER;
        e.category = '0;
        e.pos_x    = '0;
        e.pos_y    = '0;
        e.cfg_addr = addr;
        e.cfg_data = data;
        e.gap_pct  = 0;
        pending = {pending, e};
    endtask

    // Mostly matching offers clustered around one spot and queries aimed near
    // offered points at several ranges, with clears, ignored actions and misses.
    task automatic random_phase(input int count, input logic [npdb_pkg::CODE_W-1:0] code);
        longint cx;
        longint cy;
        longint ox;
        longint oy;
        int     pick;
        int     idx;
        int     spread;
        int     k;
        cx = longint'($urandom_range(30000000)) - 15000000;
        cy = longint'($urandom_range(30000000)) - 15000000;
        offered_x.delete();
        offered_y.delete();
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 46) begin
                if ($urandom_range(9) < 8) begin
                    ox = cx + jitter(6000);
                    oy = cy + jitter(6000);
                end else if ($urandom_range(1) == 1) begin
                    ox = any_coord();
                    oy = any_coord();
                end else begin
                    ox = $urandom_range(1) ? COORD_MAX : COORD_MIN;
                    oy = $urandom_range(1) ? COORD_MAX : COORD_MIN;
                end
                offered_x = {offered_x, ox};
                offered_y = {offered_y, oy};
                add_request(npdb_pkg::ACT_OFFER,
                            ($urandom_range(9) < 8) ? code :
                                npdb_pkg::CODE_W'($urandom_range(999999)),
                            ox, oy);
            end else if (pick < 89) begin
                if (offered_x.size() != 0 && $urandom_range(9) < 8) begin
                    idx = $urandom_range(offered_x.size() - 1);
                    case ($urandom_range(4))
                        0:       spread = 0;
                        1:       spread = 800;
                        2:       spread = 2500;
                        3:       spread = 7000;
                        default: spread = 40000;
                    endcase
                    ox = offered_x[idx] + jitter(spread);
                    oy = offered_y[idx] + jitter(spread);
                end else begin
                    ox = any_coord();
                    oy = any_coord();
                end
                add_request(npdb_pkg::ACT_QUERY, npdb_pkg::CODE_W'($urandom_range(999999)),
                            ox, oy);
            end else if (pick < 93) begin
                add_request(npdb_pkg::ACT_CLEAR, npdb_pkg::CODE_W'($urandom_range(999999)),
                            any_coord(), any_coord());
                offered_x.delete();
                offered_y.delete();
            end else if (pick < 97) begin
                add_request(ACT_UNUSED, npdb_pkg::CODE_W'($urandom_range(999999)),
                            any_coord(), any_coord());
            end else begin
                add_request(npdb_pkg::ACT_OFFER, npdb_pkg::CODE_W'($urandom_range(999999)),
                            cx + jitter(6000), cy + jitter(6000));
            end
        end
    endtask

    // Driver: presents one queued entry at a time. A request is taken on an edge
    // with i_start high and o_busy low, a register write on valid and ready.
    always @(posedge i_clk) begin : driver
        bit       start_nxt;
        bit       cfg_nxt;
        bit       took;
        t_outcome predicted;
        if (i_rst_n) begin
            start_nxt = i_start;
            cfg_nxt   = i_cfg_valid;
            took      = i_start && !o_busy;
            if (took) begin
                predicted = classify_and_update(on_wire);
                awaited_outcomes = {awaited_outcomes, predicted};
                requests_taken <= requests_taken + 1;
                start_nxt = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register_write(on_wire.cfg_addr, on_wire.cfg_data);
                cfg_nxt = 1'b0;
            end
            if (!start_nxt && !cfg_nxt && pending.size() != 0) begin
                if (pending[0].kind == ENTRY_CFG_WRITE) begin
                    // registers change only with no request outstanding
                    if (!took && requests_taken == results_done) begin
                        on_wire = pending.pop_front();
                        i_cfg_addr <= on_wire.cfg_addr;
                        i_cfg_data <= on_wire.cfg_data;
                        cfg_nxt = 1'b1;
                    end
                end else if ($urandom_range(99) >= pending[0].gap_pct) begin
                    on_wire = pending.pop_front();
                    i_action   <= on_wire.action;
                    i_category <= on_wire.category;
                    i_pos_x    <= on_wire.pos_x;
                    i_pos_y    <= on_wire.pos_y;
                    start_nxt = 1'b1;
                end
            end
            i_start     <= start_nxt;
            i_cfg_valid <= cfg_nxt;
        end
    end

    // Monitor: every strobe is checked field by field against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_outcome                                             want;
        logic [npdb_pkg::NUM_BINS-1:0][npdb_pkg::COUNT_W-1:0] seen_counts;
        int                                                   b;
        if (i_rst_n && o_result_strobe) begin
            if (awaited_outcomes.size() == 0) begin
                report_mismatch("result strobe with no request outstanding");
            end else begin
                want = awaited_outcomes.pop_front();
                results_done <= results_done + 1;
                seen_counts = {o_count_beyond, o_count_third, o_count_second, o_count_near};
                if (o_status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d", o_status, want.status));
                if (o_bin !== want.bin)
                    report_mismatch($sformatf("bin got %0d want %0d", o_bin, want.bin));
                if (o_nearest_dist_sq !== want.dist_sq)
                    report_mismatch($sformatf("nearest_dist_sq got %0d want %0d",
                                              o_nearest_dist_sq, want.dist_sq));
                if (o_nearest_valid !== want.valid)
                    report_mismatch($sformatf("nearest_valid got %0d want %0d",
                                              o_nearest_valid, want.valid));
                for (b = 0; b < npdb_pkg::NUM_BINS; b++)
                    if (seen_counts[b] !== want.counts[b])
                        report_mismatch($sformatf("count of bin %0d got %0d want %0d",
                                                  b, seen_counts[b], want.counts[b]));
                if (o_stored_count !== want.stored)
                    report_mismatch($sformatf("stored_count got %0d want %0d",
                                              o_stored_count, want.stored));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        logic [npdb_pkg::CODE_W-1:0] code3;

        // directed part under the reset register values: code 0, limits 1000/2000/5000
        fill_gap = 12;
        add_request(npdb_pkg::ACT_QUERY, 20'd7, 5, 5);                 // empty table
        add_request(npdb_pkg::ACT_OFFER, 20'd1, 0, 0);                 // code mismatch
        add_request(npdb_pkg::ACT_OFFER, 20'd999999, 0, 0);
        add_request(npdb_pkg::ACT_OFFER, 20'd0, 0, 0);
        add_request(npdb_pkg::ACT_QUERY, 20'd0, 0, 0);                 // zero distance
        add_request(npdb_pkg::ACT_QUERY, 20'd0, 1000, 0);              // each limit and one past it
        add_request(npdb_pkg::ACT_QUERY, 20'd0, 0, -1001);
        add_request(npdb_pkg::ACT_QUERY, 20'd0, 2000, 0);
        add_request(npdb_pkg::ACT_QUERY, 20'd0, -2001, 0);
        add_request(npdb_pkg::ACT_QUERY, 20'd0, 3000, 4000);
        add_request(npdb_pkg::ACT_QUERY, 20'd0, 3000, 4001);
        add_request(npdb_pkg::ACT_OFFER, 20'd0, COORD_MIN, COORD_MIN);
        add_request(npdb_pkg::ACT_OFFER, 20'd0, COORD_MAX, COORD_MAX);
        add_request(npdb_pkg::ACT_QUERY, 20'd0, COORD_MAX, COORD_MIN);
        add_request(npdb_pkg::ACT_QUERY, 20'd0, COORD_MIN, COORD_MAX);
        add_request(npdb_pkg::ACT_QUERY, 20'd0, COORD_MAX, COORD_MAX);
        add_request(ACT_UNUSED, 20'd0, 12345, -12345);
        add_request(npdb_pkg::ACT_CLEAR, 20'hABCDE, 0, 0);
        add_request(npdb_pkg::ACT_OFFER, 20'd0, COORD_MIN, COORD_MIN);
        add_request(npdb_pkg::ACT_QUERY, 20'd0, COORD_MAX, COORD_MAX); // largest distance there is
        add_request(ACT_UNUSED, 20'd999999, COORD_MIN, COORD_MAX);
        add_request(npdb_pkg::ACT_CLEAR, 20'd0, 0, 0);
        add_request(npdb_pkg::ACT_QUERY, 20'd0, 0, 0);

        // sender idles often enough to break up back-to-back requests
        add_cfg(npdb_pkg::CFG_WANTED_CODE, 24'h00BDC0);
        add_cfg(npdb_pkg::CFG_NEAR_LIMIT, 24'd700);
        add_cfg(npdb_pkg::CFG_MID_LIMIT, 24'd2600);
        add_cfg(npdb_pkg::CFG_FAR_LIMIT, 24'd9000);
        random_phase(185, 20'h0BDC0);

        // highest code, near limit zero, other limits at full scale
        fill_gap = 59;
        add_cfg(npdb_pkg::CFG_WANTED_CODE, 24'd999999);
        add_cfg(npdb_pkg::CFG_NEAR_LIMIT, 24'd0);
        add_cfg(npdb_pkg::CFG_MID_LIMIT, 24'hFFFFFF);
        add_cfg(npdb_pkg::CFG_FAR_LIMIT, 24'hFFFFFF);
        random_phase(185, 20'd999999);

        // limits out of order: no query lands in the second or third bin
        fill_gap = 0;
        code3 = npdb_pkg::CODE_W'($urandom_range(999999));
        add_cfg(npdb_pkg::CFG_WANTED_CODE, npdb_pkg::CFG_DATA_W'(code3));
        add_cfg(npdb_pkg::CFG_NEAR_LIMIT, 24'd3000);
        add_cfg(npdb_pkg::CFG_MID_LIMIT, 24'd1500);
        add_cfg(npdb_pkg::CFG_FAR_LIMIT, 24'd2500);
        random_phase(185, code3);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // look between edges so the driver's updates of this edge are settled
        while (pending.size() != 0 || i_start || i_cfg_valid ||
               requests_taken != results_done)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && awaited_outcomes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/npdb_pkg.sv
rtl/npdb_ram.sv
rtl/npdb_bin_cell.sv
rtl/nearest_point_distance_binner.sv
sim/tb.sv
